/* sv/rc_stick_deadband_to_command_defines.svh */
// ----------------------------------------------------------------------------
// rc_stick_deadband_to_command_defines
// Assertion macros shared by the stick command checker.
// ----------------------------------------------------------------------------
`ifndef RC_STICK_DEADBAND_TO_COMMAND_DEFINES_SVH
`define RC_STICK_DEADBAND_TO_COMMAND_DEFINES_SVH

// Same-cycle implication, sampled at the rising clock, off during reset.
`define RCSD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rcsd: assertion failed");

// Next-cycle implication, sampled at the rising clock, off during reset.
`define RCSD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rcsd: assertion failed");

`endif

/* sv/rcsd_pkg.sv */
// ----------------------------------------------------------------------------
// rcsd_pkg
// Widths, register indexes, reset values and shared types of the stick
// deadband command mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsd_pkg;

    localparam int PULSE_W    = 12;
    localparam int CMD_W      = 11;
    localparam int DZ_W       = 10;
    localparam int LIM_W      = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    // Divider geometry: |product| fits 22 bits, |span| fits 12 bits
    localparam int DIV_NUM_W  = 22;
    localparam int DIV_DEN_W  = 12;
    localparam int DIV_STEP   = 2;

    localparam logic [PULSE_W-1:0] RST_PULSE_LOW  = 12'd1000;
    localparam logic [PULSE_W-1:0] RST_PULSE_MID  = 12'd1500;
    localparam logic [PULSE_W-1:0] RST_PULSE_HIGH = 12'd2000;
    localparam logic [DZ_W-1:0]    RST_DEAD_ZONE  = 10'd25;
    localparam logic [LIM_W-1:0]   RST_FWD_LIMIT  = 10'd255;
    localparam logic [CMD_W-1:0]   RST_REV_LIMIT  = 11'h701;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PULSE_LOW  = 3'd0,
        REG_PULSE_MID  = 3'd1,
        REG_PULSE_HIGH = 3'd2,
        REG_DEAD_ZONE  = 3'd3,
        REG_DIR_SWAP   = 3'd4,
        REG_FWD_LIMIT  = 3'd5,
        REG_REV_LIMIT  = 3'd6
    } cfg_idx_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_CALC = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_LOAD = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIX  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

/* sv/rc_stick_deadband_to_command.sv */
// ----------------------------------------------------------------------------
// rc_stick_deadband_to_command
// Maps one receiver pulse width per frame onto a signed, clamped drive command.
// ----------------------------------------------------------------------------
// One pulse is taken at a time. A pulse equal to the previous one is answered
// straight after the compare, a pulse inside the deadband or on a half with zero
// span after the compare and clamp, and a pulse that needs the linear map after
// compare, one 14x12 multiply, a divider producing two quotient bits per cycle,
// then offset and clamp. s_tready is high only while no pulse is in work; a
// finished result may still wait in the output register while the next pulse
// is taken.
`default_nettype none

module rc_stick_deadband_to_command
    import rcsd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input beats
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] pulse_width
    // result beats
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata    // [10:0] drive_command,
                                                  // [11] changed, [12] just_started
);

    state_t state_reg, state_next;

    // configuration
    logic        [PULSE_W-1:0] low_reg, mid_reg, high_reg;
    logic        [DZ_W-1:0]    dz_reg;
    logic                      swap_reg;
    logic        [LIM_W-1:0]   fwd_reg;
    logic signed [CMD_W-1:0]   rev_reg;

    // channel state
    logic        [PULSE_W-1:0] prev_pulse_reg;
    logic signed [CMD_W-1:0]   prev_cmd_reg;
    logic                      started_reg;
    logic                      changed_reg;

    // work registers
    logic        [PULSE_W-1:0] pulse_reg;
    logic                      dead_reg, zspan_reg, qneg_reg;
    logic signed [13:0]        dx_reg, span_reg;
    logic signed [11:0]        scale_reg;
    logic signed [CMD_W-1:0]   base_reg, raw_reg;
    logic        [DIV_NUM_W-1:0] num_reg;
    logic        [DIV_DEN_W-1:0] den_reg;

    // output register
    logic                      m_valid_reg;
    logic signed [CMD_W-1:0]   m_cmd_reg;
    logic                      m_changed_reg, m_started_reg;

    // divider
    logic                      div_start;
    logic [DIV_NUM_W-1:0]      div_quo;
    div_stat_t                 div_stat;

    // compare / setup
    logic signed [13:0] x_s, lo_s, mid_s, hi_s, dz_s;
    logic               up_c, lo_c, same_c;
    logic signed [13:0] dx_c, span_c;
    logic signed [11:0] scale_c;
    logic signed [CMD_W-1:0] base_c, raw_c;

    // multiply
    logic signed [25:0] prod_c, prod_abs;
    logic signed [13:0] span_abs;

    // offset and clamp
    logic signed [22:0] q_s;
    logic signed [23:0] val_c;
    logic signed [CMD_W-1:0] clamp_c;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        x_s    = $signed({2'b00, pulse_reg});
        lo_s   = $signed({2'b00, low_reg});
        mid_s  = $signed({2'b00, mid_reg});
        hi_s   = $signed({2'b00, high_reg});
        dz_s   = $signed({4'b0000, dz_reg});
        up_c   = (x_s >= mid_s + dz_s);
        lo_c   = (x_s <= mid_s - dz_s);
        same_c = (pulse_reg == prev_pulse_reg);
        if (up_c) begin
            dx_c    = x_s - mid_s;
            span_c  = hi_s - mid_s;
            scale_c = swap_reg ? 12'(rev_reg) : $signed({2'b00, fwd_reg});
            base_c  = '0;
            raw_c   = scale_c[CMD_W-1:0];
        end else begin
            dx_c    = x_s - lo_s;
            span_c  = mid_s - lo_s;
            base_c  = swap_reg ? $signed({1'b0, fwd_reg}) : rev_reg;
            scale_c = 12'sd0 - 12'(base_c);
            raw_c   = base_c;
        end
    end

    always_comb begin
        prod_c   = dx_reg * scale_reg;
        prod_abs = prod_c[25] ? -prod_c : prod_c;
        span_abs = span_reg[13] ? -span_reg : span_reg;
    end

    always_comb begin
        q_s   = qneg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        val_c = zspan_reg ? 24'(raw_reg) : 24'(q_s) + 24'(base_reg);
        if (val_c < 24'(rev_reg)) begin
            clamp_c = rev_reg;
        end else if (val_c > $signed({14'd0, fwd_reg})) begin
            clamp_c = $signed({1'b0, fwd_reg});
        end else begin
            clamp_c = val_c[CMD_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_CALC;
            ST_CALC: begin
                if (same_c) begin
                    state_next = ST_FIN;
                end else if (!up_c && !lo_c) begin
                    state_next = ST_FIX;
                end else if (span_c == '0) begin
                    state_next = ST_FIX;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:  if (div_stat.done) state_next = ST_FIX;
            ST_FIX:  state_next = ST_FIN;
            ST_FIN:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign div_start = (state_reg == ST_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            low_reg        <= RST_PULSE_LOW;
            mid_reg        <= RST_PULSE_MID;
            high_reg       <= RST_PULSE_HIGH;
            dz_reg         <= RST_DEAD_ZONE;
            swap_reg       <= 1'b0;
            fwd_reg        <= RST_FWD_LIMIT;
            rev_reg        <= RST_REV_LIMIT;
            prev_pulse_reg <= '0;
            prev_cmd_reg   <= '0;
            started_reg    <= 1'b0;
            changed_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_PULSE_LOW:  low_reg  <= cfg_wdata;
                    REG_PULSE_MID:  mid_reg  <= cfg_wdata;
                    REG_PULSE_HIGH: high_reg <= cfg_wdata;
                    REG_DEAD_ZONE:  dz_reg   <= cfg_wdata[DZ_W-1:0];
                    REG_DIR_SWAP:   swap_reg <= cfg_wdata[0];
                    REG_FWD_LIMIT:  fwd_reg  <= cfg_wdata[LIM_W-1:0];
                    REG_REV_LIMIT:  rev_reg  <= cfg_wdata[CMD_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_CALC) begin
                changed_reg <= 1'b0;
                if (!same_c) prev_pulse_reg <= pulse_reg;
            end
            if (state_reg == ST_FIX) begin
                if (dead_reg) begin
                    // deadband: report a change only when leaving a nonzero command
                    prev_cmd_reg <= '0;
                    changed_reg  <= (prev_cmd_reg != '0);
                end else begin
                    changed_reg <= 1'b1;
                    if (val_c != '0) begin
                        prev_cmd_reg <= clamp_c;
                        started_reg  <= (prev_cmd_reg == '0);
                    end else begin
                        prev_cmd_reg <= '0;
                    end
                end
            end
            if (state_reg == ST_FIN && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            pulse_reg <= s_tdata[PULSE_W-1:0];
        end
        if (state_reg == ST_CALC) begin
            dead_reg  <= !up_c && !lo_c;
            zspan_reg <= (span_c == '0);
            dx_reg    <= dx_c;
            span_reg  <= span_c;
            scale_reg <= scale_c;
            base_reg  <= base_c;
            raw_reg   <= raw_c;
        end
        if (state_reg == ST_MUL) begin
            num_reg  <= prod_abs[DIV_NUM_W-1:0];
            den_reg  <= span_abs[DIV_DEN_W-1:0];
            qneg_reg <= prod_c[25] ^ span_reg[13];
        end
        if (state_reg == ST_FIN && (!m_valid_reg || m_tready)) begin
            m_cmd_reg     <= prev_cmd_reg;
            m_changed_reg <= changed_reg;
            m_started_reg <= started_reg;
        end
    end

    rcsd_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W),
        .STEP  (DIV_STEP)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (den_reg),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - CMD_W - 2)'(0), m_started_reg, m_changed_reg, m_cmd_reg};

endmodule

`default_nettype wire

/* sv/rcsd_div.sv */
// ----------------------------------------------------------------------------
// rcsd_div
// Iterative unsigned restoring divider, STEP quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsd_div
    import rcsd_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W,
    parameter int STEP  = DIV_STEP
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic      [NUM_W-1:0] quotient,
    output div_stat_t             stat
);

    localparam int STEPS = NUM_W / STEP;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    // Shift the dividend out of the top of quo_reg, quotient bits in at the bottom
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        ge       = 1'b0;
        for (int i = 0; i < STEP; i++) begin
            trial    = {rem_next, quo_next[NUM_W-1]};
            ge       = (trial >= {1'b0, den_reg});
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_next[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* sv/rcsd_checker.sv */
// ----------------------------------------------------------------------------
// rcsd_checker
// Port-level checks of the stick deadband command mapper, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rc_stick_deadband_to_command_defines.svh"

module rcsd_checker
    import rcsd_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata
);

    // stalled result beat holds
    `RCSD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a taken pulse keeps the input closed until it is worked off
    `RCSD_ASSERT_NXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // no result appears the cycle after a pulse is taken
    `RCSD_ASSERT_NXT(a_no_instant_out, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

    // pad bits of the result stay clear
    `RCSD_ASSERT_IMP(a_out_pad, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:CMD_W+2] == '0)

endmodule

bind rc_stick_deadband_to_command rcsd_checker u_rcsd_checker (.*);

`default_nettype wire
